// File: rtl/core/sart_pkg.sv
package sart_pkg;

   // IP protocol number of TCP.
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   // An address of zero marks a slot that holds no entry.
   localparam logic [31:0] EMPTY_ADDR = 32'd0;
   // Width of the slot field of a result beat.
   localparam int unsigned SLOT_W = 4;

   localparam logic ACTION_PACKET = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [31:0] time_now;
      logic [31:0] query_address;
   } req_type;

   typedef struct packed {
      logic              recorded;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       seen_time;
   } rsp_type;

   // One table entry as it sits in the memory.
   typedef struct packed {
      logic [31:0] address;
      logic [31:0] seen_time;
   } entry_type;

endpackage

// File: rtl/core/sart_mem.sv
module sart_mem
   import sart_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  entry_type                  wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output entry_type                  rd_data
);

   logic [ENTRIES-1:0] valid_ff;
   entry_type          mem_ff [ENTRIES];
   entry_type          rd_raw_ff;
   logic               rd_valid_ff;

   // Valid bits stand in for clearing the array: an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

// File: rtl/core/sart_ctrl.sv
module sart_ctrl
   import sart_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_type                    req_item,
   input  logic [31:0]                local_address,
   output logic                       rsp_valid,
   output rsp_type                    rsp_item,
   output logic                       mem_wr_en,
   output logic [$clog2(ENTRIES)-1:0] mem_wr_addr,
   output entry_type                  mem_wr_data,
   output logic                       mem_rd_en,
   output logic [$clog2(ENTRIES)-1:0] mem_rd_addr,
   input  entry_type                  mem_rd_data
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_type;

   state_type        state_ff;
   req_type          item_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_done_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_item_ff;

   logic             accept;
   logic             pass;
   logic             item_query;
   logic             is_empty;
   logic             is_match;
   logic             chk_last;
   logic [IDX_W-1:0] ptr_next;
   logic             done;
   logic             ptr_upd;
   logic [IDX_W-1:0] wr_idx;
   rsp_type          dec_item;

   assign accept = start && (state_ff == ST_IDLE);

   // Queries for the empty address and filtered packets are answered without a scan.
   assign pass = (req_item.action == ACTION_QUERY)
                 ? (req_item.query_address != EMPTY_ADDR)
                 : ((req_item.protocol == PROTO_TCP)
                    && (req_item.destination_address == local_address));

   assign item_query = (item_ff.action == ACTION_QUERY);
   assign is_empty   = (mem_rd_data.address == EMPTY_ADDR);
   assign is_match   = item_query ? (mem_rd_data.address == item_ff.query_address)
                                  : (mem_rd_data.address == item_ff.source_address);
   assign chk_last   = (chk_idx_ff == LAST);
   assign ptr_next   = (ptr_ff == LAST) ? '0 : ptr_ff + 1'b1;

   always_comb begin
      done     = 1'b0;
      ptr_upd  = 1'b0;
      wr_idx   = chk_idx_ff;
      dec_item = '0;
      mem_wr_en = 1'b0;
      if ((state_ff == ST_SCAN) && chk_vld_ff) begin
         if (item_query) begin
            priority if (is_match) begin
               done               = 1'b1;
               dec_item.hit       = 1'b1;
               dec_item.slot      = SLOT_W'(chk_idx_ff);
               dec_item.seen_time = mem_rd_data.seen_time;
            end else if (chk_last) begin
               done = 1'b1;
            end else begin
               done = 1'b0;
            end
         end else begin
            // An empty slot is taken before a later match could be seen.
            priority if (is_empty) begin
               done      = 1'b1;
               ptr_upd   = 1'b1;
               mem_wr_en = 1'b1;
            end else if (is_match) begin
               done         = 1'b1;
               mem_wr_en    = 1'b1;
               dec_item.hit = 1'b1;
            end else if (chk_last) begin
               done      = 1'b1;
               ptr_upd   = 1'b1;
               mem_wr_en = 1'b1;
               wr_idx    = ptr_next;
            end else begin
               done = 1'b0;
            end
            dec_item.recorded = done;
            dec_item.slot     = SLOT_W'(wr_idx);
         end
      end
   end

   assign mem_wr_addr = wr_idx;
   assign mem_wr_data = '{address: item_ff.source_address, seen_time: item_ff.time_now};
   assign mem_rd_en   = (state_ff == ST_SCAN) && !rd_done_ff;
   assign mem_rd_addr = rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_done_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= mem_rd_en;
         if (mem_rd_en) begin
            chk_idx_ff <= rd_idx_ff;
            if (rd_idx_ff == LAST) begin
               rd_done_ff <= 1'b1;
            end else begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  item_ff <= req_item;
                  if (pass) begin
                     state_ff   <= ST_SCAN;
                     rd_idx_ff  <= '0;
                     rd_done_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_item_ff  <= '0;
                  end
               end
            end
            ST_SCAN: begin
               if (done) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_item_ff  <= dec_item;
                  if (ptr_upd) begin
                     ptr_ff <= wr_idx;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: rtl/core/source_address_recency_table.sv
// Source address recency table. The block holds ENTRIES slots, each with an IPv4 source
// address and the time it was last seen, and takes one command beat at a time: a beat is
// accepted at a clock edge with start high and busy low. A packet beat is recorded only when
// its protocol is TCP and its destination equals the local_address register, written through
// csr_we and csr_wdata. The user must write it only while the block is idle; the block
// does not enforce this. Recording walks the slots from zero and stops at the first empty
// slot, which takes the address, or at the first slot holding the same address, whose time
// is refreshed; with no such slot the round-robin pointer advances and its slot is
// overwritten. A query beat returns whether an address is present, its slot and its time.
// Each item produces exactly one result beat, shown on rsp_item for one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take every beat it sees.
// The table sits in a single-port-read memory with a registered read, and the walk reads
// one slot per cycle with the compare in the cycle after the read. A scanning item keeps
// busy high until its walk stops. The result beat is shown in the first cycle with busy
// low, when the next beat may already be accepted. A filtered packet or a query for
// address zero never raises busy and is answered the next cycle.
// The table is empty after reset with no clearing pass; valid bits per slot cover that.
module source_address_recency_table
   import sart_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   // Address of this station; only packets sent to it are recorded.
   logic [31:0] local_address_ff;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
      end else if (csr_we) begin
         local_address_ff <= csr_wdata;
      end
   end

   // The controller walks the table and makes the single write of each recorded packet.
   sart_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .local_address (local_address_ff),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   // Address and time of a slot share one memory word.
   sart_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: rtl/core/sart_checker.sv
module sart_checker
   import sart_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // After a reset edge nothing is in flight.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // An accepted beat is either answered at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted beat neither answered nor busy");

   // A result that neither records nor hits carries no slot and no time.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.recorded && !rsp_item.hit)
         |-> ((rsp_item.slot == '0) && (rsp_item.seen_time == '0)))
      else $error("miss or filtered result carries slot or time");

   // A recorded packet never reports a stored time.
   a_record_no_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.recorded) |-> (rsp_item.seen_time == '0))
      else $error("recorded packet reports a time");

endmodule

bind source_address_recency_table sart_checker u_sart_checker (.*);
